>>> src/size_class_block_allocator_macros.svh
// Assertion macros used by the allocator checker
`ifndef SIZE_CLASS_BLOCK_ALLOCATOR_MACROS_SVH
`define SIZE_CLASS_BLOCK_ALLOCATOR_MACROS_SVH

// same-cycle implication, masked during reset
`define SCBA_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: implication check failed");

// next-cycle implication, masked during reset
`define SCBA_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

// next-cycle implication, live through reset
`define SCBA_ASSERT_RST(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("%m: reset check failed");

`endif

>>> src/scba_pkg.sv
// Shared constants, types and helper functions of the size class allocator
package scba_pkg;

  localparam int NUM_CLASSES = 4;
  localparam int POOL_BYTES  = 32 * 1024;

  localparam int ADDR_W  = 32;
  localparam int SIZE_W  = 16;
  localparam int CLS_W   = 3;
  localparam int IDX_W   = $clog2(POOL_BYTES / 4);
  localparam int CNT_W   = IDX_W + 1;
  localparam int LINK_AW = $clog2(POOL_BYTES / 2);
  localparam int CSEL_W  = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_COMMIT
  } state_t;

  typedef enum logic [1:0] {
    OP_FAIL,
    OP_POP,
    OP_FRESH,
    OP_PUSH
  } op_t;

  typedef struct packed {
    logic ready;
    logic decide;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

  function automatic int block_bytes(int c);
    return 4 << c;
  endfunction

  function automatic int class_blocks(int c);
    return POOL_BYTES >> (c + 2);
  endfunction

  function automatic int class_span(int c);
    return class_blocks(c) * block_bytes(c);
  endfunction

  function automatic int class_slice(int c);
    int off;
    off = 0;
    for (int k = 0; k < c; k++) begin
      off += class_blocks(k);
    end
    return off;
  endfunction

endpackage

>>> src/scba_ifs.sv
// Request and response channel interfaces of the size class allocator
interface scba_req_if;
  logic                        valid;
  logic                        ready;
  logic                        action;
  logic [scba_pkg::SIZE_W-1:0] request_size;
  logic [scba_pkg::ADDR_W-1:0] block_address;

  modport source (output valid, output action, output request_size,
                  output block_address, input ready);
  modport sink (input valid, input action, input request_size,
                input block_address, output ready);
endinterface

interface scba_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [scba_pkg::ADDR_W-1:0] granted_address;
  logic                        success;
  logic [scba_pkg::CLS_W-1:0]  chosen_class;

  modport source (output valid, output granted_address, output success,
                  output chosen_class, input ready);
  modport sink (input valid, input granted_address, input success,
                input chosen_class, output ready);
endinterface

>>> src/scba_ctrl.sv
// Sequencing state machine of the size class allocator
module scba_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  input  scba_pkg::status_t sts,
  output scba_pkg::cmd_t    cmd
);

  scba_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= scba_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      scba_pkg::ST_IDLE: begin
        cmd.ready = 1'b1;
        if (req_valid) begin
          state_next = scba_pkg::ST_DECIDE;
        end
      end
      scba_pkg::ST_DECIDE: begin
        cmd.decide = 1'b1;
        state_next = scba_pkg::ST_COMMIT;
      end
      scba_pkg::ST_COMMIT: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_next = scba_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = scba_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

>>> src/scba_dp.sv
// Datapath of the size class allocator: class tables, link memory, result register
module scba_dp (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [scba_pkg::ADDR_W-1:0] cfg_wdata,
  input  scba_pkg::cmd_t              cmd,
  output scba_pkg::status_t           sts,
  input  logic                        in_load,
  input  logic                        in_action,
  input  logic [scba_pkg::SIZE_W-1:0] in_size,
  input  logic [scba_pkg::ADDR_W-1:0] in_addr,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [scba_pkg::ADDR_W-1:0] out_granted,
  output logic                        out_success,
  output logic [scba_pkg::CLS_W-1:0]  out_class
);

  localparam int NC = scba_pkg::NUM_CLASSES;

  logic [scba_pkg::ADDR_W-1:0] pool_base;

  logic                        act;
  logic [scba_pkg::SIZE_W-1:0] size;
  logic [scba_pkg::ADDR_W-1:0] addr;

  logic [scba_pkg::IDX_W-1:0] head  [NC];
  logic [scba_pkg::CNT_W-1:0] count [NC];
  logic [scba_pkg::CNT_W-1:0] fresh [NC];

  logic [scba_pkg::IDX_W-1:0] link [2**scba_pkg::LINK_AW];
  logic [scba_pkg::IDX_W-1:0] rdata;

  scba_pkg::op_t               d_op;
  logic [scba_pkg::CSEL_W-1:0] d_cls;
  logic [scba_pkg::IDX_W-1:0]  d_idx;

  logic [NC-1:0]               fit;
  logic [NC-1:0]               avail;
  logic [NC-1:0]               in_pool;
  logic [NC-1:0]               cand;
  logic [scba_pkg::ADDR_W-1:0] off     [NC];
  logic [scba_pkg::IDX_W-1:0]  off_idx [NC];

  logic                         sel_found;
  scba_pkg::op_t                sel_op;
  logic [scba_pkg::CSEL_W-1:0]  sel_cls;
  logic [scba_pkg::IDX_W-1:0]   sel_idx;
  logic [scba_pkg::LINK_AW-1:0] rd_addr;

  logic [scba_pkg::LINK_AW-1:0] wr_addr;
  logic [scba_pkg::IDX_W-1:0]   head_sel;
  logic [scba_pkg::ADDR_W-1:0]  grant_addr;

  assign sts.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_base <= '0;
    end else if (cfg_we) begin
      pool_base <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (in_load) begin
      act  <= in_action;
      size <= in_size;
      addr <= in_addr;
    end
  end

  always_comb begin
    for (int c = 0; c < NC; c++) begin
      fit[c]     = size <= scba_pkg::SIZE_W'(scba_pkg::block_bytes(c));
      avail[c]   = (count[c] != '0) ||
                   (fresh[c] < scba_pkg::CNT_W'(scba_pkg::class_blocks(c)));
      off[c]     = addr - pool_base - scba_pkg::ADDR_W'(c * scba_pkg::POOL_BYTES);
      in_pool[c] = off[c] < scba_pkg::ADDR_W'(scba_pkg::class_span(c));
      off_idx[c] = scba_pkg::IDX_W'(off[c] >> (c + 2));
      cand[c]    = act ? (fit[c] && in_pool[c]) : (fit[c] && avail[c]);
    end
  end

  always_comb begin
    sel_found = 1'b0;
    sel_op    = scba_pkg::OP_FAIL;
    sel_cls   = '0;
    sel_idx   = '0;
    rd_addr   = '0;
    for (int c = 0; c < NC; c++) begin
      if (!sel_found && cand[c]) begin
        sel_found = 1'b1;
        sel_cls   = scba_pkg::CSEL_W'(c);
        if (act) begin
          sel_idx = off_idx[c];
          if (({1'b0, off_idx[c]} < fresh[c]) && (count[c] < fresh[c])) begin
            sel_op = scba_pkg::OP_PUSH;
          end
        end else if (count[c] != '0) begin
          sel_op  = scba_pkg::OP_POP;
          sel_idx = head[c];
          rd_addr = scba_pkg::LINK_AW'(scba_pkg::class_slice(c)) +
                    scba_pkg::LINK_AW'(head[c]);
        end else begin
          sel_op  = scba_pkg::OP_FRESH;
          sel_idx = fresh[c][scba_pkg::IDX_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_op <= scba_pkg::OP_FAIL;
    end else if (cmd.decide) begin
      d_op <= sel_op;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      d_cls <= sel_cls;
      d_idx <= sel_idx;
    end
  end

  always_comb begin
    wr_addr  = '0;
    head_sel = '0;
    for (int c = 0; c < NC; c++) begin
      if (d_cls == scba_pkg::CSEL_W'(c)) begin
        wr_addr  = scba_pkg::LINK_AW'(scba_pkg::class_slice(c)) +
                   scba_pkg::LINK_AW'(d_idx);
        head_sel = head[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && d_op == scba_pkg::OP_PUSH) begin
      link[wr_addr] <= head_sel;
    end
    if (cmd.decide && sel_op == scba_pkg::OP_POP) begin
      rdata <= link[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < NC; c++) begin
        head[c]  <= '0;
        count[c] <= '0;
        fresh[c] <= '0;
      end
    end else if (cmd.commit) begin
      for (int c = 0; c < NC; c++) begin
        if (d_cls == scba_pkg::CSEL_W'(c)) begin
          unique case (d_op)
            scba_pkg::OP_POP: begin
              head[c]  <= rdata;
              count[c] <= count[c] - 1'b1;
            end
            scba_pkg::OP_FRESH: begin
              fresh[c] <= fresh[c] + 1'b1;
            end
            scba_pkg::OP_PUSH: begin
              head[c]  <= d_idx;
              count[c] <= count[c] + 1'b1;
            end
            scba_pkg::OP_FAIL: begin
            end
            default: begin
            end
          endcase
        end
      end
    end
  end

  assign grant_addr = pool_base +
                      scba_pkg::ADDR_W'(d_cls) * scba_pkg::ADDR_W'(scba_pkg::POOL_BYTES) +
                      (scba_pkg::ADDR_W'(d_idx) << (4'(d_cls) + 4'd2));

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_success <= d_op != scba_pkg::OP_FAIL;
      out_class   <= (d_op != scba_pkg::OP_FAIL) ? scba_pkg::CLS_W'(d_cls) : '0;
      out_granted <= (d_op == scba_pkg::OP_POP || d_op == scba_pkg::OP_FRESH) ?
                     grant_addr : '0;
    end
  end

endmodule

>>> src/size_class_block_allocator.sv
// Top level of the size class block allocator
//
// Requests arrive on req as one beat each: action 0 allocates a block of at
// least request_size bytes, action 1 frees block_address. Every request gives
// exactly one response beat on rsp with granted_address, success and
// chosen_class. Class c holds blocks of 4 << c bytes in a pool of its own;
// pools lie back to back from pool_base. The user must write pool_base
// through cfg_we/cfg_wdata only while no request is in flight; the block
// does not enforce this. A request is accepted, then its class is chosen
// and the link memory read, then the class tables are updated and the
// result register loaded. req.ready is high only while the sequencer is
// idle and out of reset, so a new request is accepted only after the last
// one has loaded its response.
// A stalled rsp holds its beat; the next request is still accepted and waits
// in the commit step until the result register frees.
// Reset empties all free lists and fresh counters and clears pool_base; the
// link memory is not cleared and needs no sweep.
module size_class_block_allocator (
  input  logic                        clk,
  input  logic                        rst,
  scba_req_if.sink                    req,
  scba_rsp_if.source                  rsp,
  input  logic                        cfg_we,
  input  logic [scba_pkg::ADDR_W-1:0] cfg_wdata
);

  scba_pkg::cmd_t    cmd;
  scba_pkg::status_t sts;

  assign req.ready = cmd.ready && !rst;

  scba_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  scba_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .cmd         (cmd),
    .sts         (sts),
    .in_load     (req.valid && req.ready),
    .in_action   (req.action),
    .in_size     (req.request_size),
    .in_addr     (req.block_address),
    .out_valid   (rsp.valid),
    .out_ready   (rsp.ready),
    .out_granted (rsp.granted_address),
    .out_success (rsp.success),
    .out_class   (rsp.chosen_class)
  );

endmodule

>>> src/scba_checker.sv
// Port checker of the size class allocator and its bind
`include "size_class_block_allocator_macros.svh"

module scba_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        req_valid,
  input logic                        req_ready,
  input logic                        rsp_valid,
  input logic                        rsp_ready,
  input logic [scba_pkg::ADDR_W-1:0] granted_address,
  input logic                        success,
  input logic [scba_pkg::CLS_W-1:0]  chosen_class
);

  `SCBA_ASSERT_NXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid && $stable(granted_address) && $stable(success) && $stable(chosen_class))
  `SCBA_ASSERT_IMP(a_fail_zero, clk, rst, rsp_valid && !success, granted_address == '0 && chosen_class == '0)
  `SCBA_ASSERT_NXT(a_one_in_flight, clk, rst, req_valid && req_ready, !req_ready)
  `SCBA_ASSERT_IMP(a_class_range, clk, rst, rsp_valid, {1'b0, chosen_class} < 4'(scba_pkg::NUM_CLASSES))
  `SCBA_ASSERT_RST(a_reset_empty, clk, rst, !rsp_valid)

endmodule

bind size_class_block_allocator scba_checker u_scba_checker (
  .clk             (clk),
  .rst             (rst),
  .req_valid       (req.valid),
  .req_ready       (req.ready),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .granted_address (rsp.granted_address),
  .success         (rsp.success),
  .chosen_class    (rsp.chosen_class)
);
